>>> src/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, round constants and helper functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

  // input request: one big-endian message word
  typedef struct packed {
    logic [31:0] msg_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } sh_in_t;

  // output request: one quarter of the digest
  typedef struct packed {
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
  } sh_out_t;

  // source of a word pushed into the block buffer
  typedef enum logic [2:0] {
    SEL_MSG,
    SEL_PAD80,
    SEL_ZERO,
    SEL_LEN_HI,
    SEL_LEN_LO
  } word_sel_e;

  // controller to datapath commands
  typedef struct packed {
    logic      push;
    word_sel_e sel;
    logic      add_len;
    logic      load_work;
    logic      round;
    logic [5:0] rnd;
    logic      update;
    logic      reinit;
    logic [1:0] part;
  } sh_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic [3:0] pos;
    logic       wrap;
  } sh_sts_t;

  localparam logic [7:0]  PAD_BYTE     = 8'h80;
  localparam logic [3:0]  LEN_WORD_POS = 4'd14;
  localparam logic [5:0]  LAST_ROUND   = 6'd63;
  localparam logic [1:0]  LAST_PART    = 2'd3;

  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // rotate right by a constant amount
  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned s);
    return (v >> s) | (v << (32 - s));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] v);
    return rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] v);
    return rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] v);
    return rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] v);
    return rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

>>> src/sha256_ctrl.sv
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer: takes message words, drives padding, compression rounds,
// hash update and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl
  import sha256_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sh_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sh_cmd_t cmd_o,
  input  sh_sts_t sts_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_UPDATE,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    PH_80,
    PH_ZERO,
    PH_LO,
    PH_DONE
  } phase_e;

  state_e     state_q;
  phase_e     phase_q;
  logic       pad_q;
  logic [5:0] rnd_q;
  logic [1:0] part_q;
  logic       in_acc;
  logic       out_acc;
  logic       full_last;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_acc     = out_valid_o & out_ready_i;
  // a byte count of four or more takes the whole word
  assign full_last   = in_data_i.byte_count[2];

  // command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = SEL_MSG;
    cmd_o.rnd  = rnd_q;
    cmd_o.part = part_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_o.push      = 1'b1;
          cmd_o.add_len   = 1'b1;
          cmd_o.load_work = sts_i.wrap;
        end
      end
      ST_PAD: begin
        cmd_o.push      = 1'b1;
        cmd_o.load_work = sts_i.wrap;
        unique case (phase_q)
          PH_80:   cmd_o.sel = SEL_PAD80;
          PH_ZERO: cmd_o.sel = (sts_i.pos == LEN_WORD_POS) ? SEL_LEN_HI : SEL_ZERO;
          PH_LO:   cmd_o.sel = SEL_LEN_LO;
          default: cmd_o.push = 1'b0;
        endcase
      end
      ST_ROUND:  cmd_o.round  = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_OUT:    cmd_o.reinit = out_acc && (part_q == LAST_PART);
      default: ;
    endcase
  end

  // state and sequencing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_80;
      pad_q   <= 1'b0;
      rnd_q   <= '0;
      part_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          rnd_q <= '0;
          if (in_acc) begin
            if (in_data_i.last_word) begin
              pad_q   <= 1'b1;
              phase_q <= full_last ? PH_80 : PH_ZERO;
            end
            if (sts_i.wrap) begin
              state_q <= ST_ROUND;
            end else if (in_data_i.last_word) begin
              state_q <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          rnd_q <= '0;
          unique case (phase_q)
            PH_80:   phase_q <= PH_ZERO;
            PH_ZERO: if (sts_i.pos == LEN_WORD_POS) phase_q <= PH_LO;
            PH_LO:   phase_q <= PH_DONE;
            default: ;
          endcase
          if (sts_i.wrap) begin
            state_q <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == LAST_ROUND) begin
            state_q <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          part_q <= '0;
          if (phase_q == PH_DONE) begin
            state_q <= ST_OUT;
          end else if (pad_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (out_acc) begin
            part_q <= part_q + 2'd1;
            if (part_q == LAST_PART) begin
              state_q <= ST_IDLE;
              pad_q   <= 1'b0;
              phase_q <= PH_80;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> src/sha256_datapath.sv
// ----------------------------------------------------------------------------
// sha256_datapath
// Block buffer with message schedule, working variables, round function,
// hash state and message length counter.
// ----------------------------------------------------------------------------
module sha256_datapath
  import sha256_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  sh_in_t  in_data_i,
  input  sh_cmd_t cmd_i,
  output sh_sts_t sts_o,
  output sh_out_t out_data_o
);

  logic [31:0] w_q    [16];
  logic [31:0] work_q [8];
  logic [31:0] hash_q [8];
  logic [63:0] len_q;
  logic [3:0]  pos_q;

  logic [2:0]  cnt;
  logic [31:0] msg_w;
  logic [31:0] push_w;
  logic [31:0] sched_w;
  logic [31:0] t1;
  logic [31:0] t2;
  logic [63:0] len_add;

  // buffer at its last slot: a push now completes the block
  assign sts_o.pos  = pos_q;
  assign sts_o.wrap = (pos_q == 4'd15);

  // byte count clamped to four
  assign cnt = in_data_i.byte_count[2] ? 3'd4 : in_data_i.byte_count;

  // last word: keep the valid bytes and place the pad byte after them; a full word passes unchanged
  always_comb begin
    msg_w = in_data_i.msg_word;
    if (in_data_i.last_word) begin
      unique case (cnt)
        3'd0:    msg_w = {PAD_BYTE, 24'h0};
        3'd1:    msg_w = {in_data_i.msg_word[31:24], PAD_BYTE, 16'h0};
        3'd2:    msg_w = {in_data_i.msg_word[31:16], PAD_BYTE, 8'h0};
        3'd3:    msg_w = {in_data_i.msg_word[31:8], PAD_BYTE};
        default: msg_w = in_data_i.msg_word;
      endcase
    end
  end

  // pushed word select
  always_comb begin
    unique case (cmd_i.sel)
      SEL_MSG:    push_w = msg_w;
      SEL_PAD80:  push_w = {PAD_BYTE, 24'h0};
      SEL_LEN_HI: push_w = len_q[63:32];
      SEL_LEN_LO: push_w = len_q[31:0];
      default:    push_w = '0;
    endcase
  end

  assign len_add = in_data_i.last_word ? {58'h0, cnt, 3'b000} : 64'd32;

  // message schedule word for this round
  assign sched_w = (cmd_i.rnd < 6'd16) ? w_q[0]
                 : w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);

  // round function
  assign t1 = work_q[7] + big_sigma1(work_q[4])
            + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
            + K[cmd_i.rnd] + sched_w;
  assign t2 = big_sigma0(work_q[0])
            + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2])
               ^ (work_q[1] & work_q[2]));

  // block buffer, shifted on every push and every round
  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.round) begin
      for (int i = 0; i < 15; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[15] <= cmd_i.push ? push_w : sched_w;
    end
  end

  // working variables
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_work) begin
      for (int i = 0; i < 8; i++) begin
        work_q[i] <= hash_q[i];
      end
    end else if (cmd_i.round) begin
      for (int i = 1; i < 8; i++) begin
        work_q[i] <= work_q[i-1];
      end
      work_q[4] <= work_q[3] + t1;
      work_q[0] <= t1 + t2;
    end
  end

  // hash state, length and word position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= IV[i];
      end
      len_q <= '0;
      pos_q <= '0;
    end else begin
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= IV[i];
        end
        len_q <= '0;
        pos_q <= '0;
      end else begin
        if (cmd_i.update) begin
          for (int i = 0; i < 8; i++) begin
            hash_q[i] <= hash_q[i] + work_q[i];
          end
        end
        if (cmd_i.add_len) begin
          len_q <= len_q + len_add;
        end
        if (cmd_i.push) begin
          pos_q <= pos_q + 4'd1;
        end
      end
    end
  end

  // digest output
  always_comb begin
    out_data_o.digest_part = {hash_q[{cmd_i.part, 1'b0}], hash_q[{cmd_i.part, 1'b1}]};
    out_data_o.part_index  = cmd_i.part;
    out_data_o.last_part   = (cmd_i.part == LAST_PART);
  end

endmodule

>>> src/sha256_hash_top.sv
// The hasher takes one message word per cycle while idle; the sixteenth word of
// a block starts 64 rounds on the single round unit and one hash update, and
// input is held off until they are done. After the last word, padding fills one
// or two blocks, then four digest parts are output, held while the receiver stalls.
// Reset loads the SHA-256 initial hash values and clears length and position.
// ----------------------------------------------------------------------------
// sha256_hash_top
// SHA-256 message hasher: message words in, four 64-bit digest parts out.
// ----------------------------------------------------------------------------
module sha256_hash_top
  import sha256_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  sh_in_t  in_data_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output sh_out_t out_data_o
);

  sh_cmd_t cmd;
  sh_sts_t sts;

  // sequencer
  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // hash datapath
  sha256_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> tb/sv/sha256_hash_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_checker
// Watches both request channels of the hasher, keeps its own SHA-256 state,
// queues the four digest parts each final word produces and compares every
// accepted output request against the oldest queued part.
// ----------------------------------------------------------------------------
module sha256_hash_checker
  import sha256_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_ready_i,
  input  sh_in_t  in_data_i,
  input  logic    out_valid_i,
  input  logic    out_ready_i,
  input  sh_out_t out_data_i,
  output int      mismatch_count_o,
  output int      pending_o,
  output int      parts_checked_o
);

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [3:0] LEN_SLOT   = 4'd14;

  // predicted hasher state
  logic [31:0] hash_st   [8];
  logic [31:0] blk_words [16];
  logic [63:0] msg_bits;
  logic [3:0]  word_pos;

  sh_out_t digest_q [$];
  int      mismatches = 0;
  int      parts_seen = 0;

  function automatic logic [31:0] rot_right(input logic [31:0] v, input int s);
    logic [63:0] twice;
    twice = {v, v} >> s;
    return twice[31:0];
  endfunction

  // store one word in the block buffer, compress when the block is full
  function automatic void load_block_word(input logic [31:0] v);
    logic [31:0] w [16];
    logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
    logic [31:0] t1, t2, wr, x15, x2;
    blk_words[word_pos] = v;
    word_pos = word_pos + 4'd1;
    if (word_pos != 4'd0) return;
    for (int i = 0; i < 16; i++) w[i] = blk_words[i];
    va = hash_st[0]; vb = hash_st[1]; vc = hash_st[2]; vd = hash_st[3];
    ve = hash_st[4]; vf = hash_st[5]; vg = hash_st[6]; vh = hash_st[7];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        x15 = w[(r - 15) % 16];
        x2  = w[(r - 2) % 16];
        wr = w[r % 16]
           + (rot_right(x15, 7) ^ rot_right(x15, 18) ^ (x15 >> 3))
           + w[(r - 7) % 16]
           + (rot_right(x2, 17) ^ rot_right(x2, 19) ^ (x2 >> 10));
        w[r % 16] = wr;
      end
      t1 = vh + (rot_right(ve, 6) ^ rot_right(ve, 11) ^ rot_right(ve, 25))
         + ((ve & vf) ^ (~ve & vg)) + ROUND_K[r] + wr;
      t2 = (rot_right(va, 2) ^ rot_right(va, 13) ^ rot_right(va, 22))
         + ((va & vb) ^ (va & vc) ^ (vb & vc));
      vh = vg; vg = vf; vf = ve; ve = vd + t1;
      vd = vc; vc = vb; vb = va; va = t1 + t2;
    end
    hash_st[0] += va; hash_st[1] += vb; hash_st[2] += vc; hash_st[3] += vd;
    hash_st[4] += ve; hash_st[5] += vf; hash_st[6] += vg; hash_st[7] += vh;
  endfunction

  // absorb one message word; a final word pads, closes and queues the digest
  function automatic void absorb_word(input sh_in_t req);
    int          nbytes;
    logic [31:0] keep;
    sh_out_t     part;
    if (!req.last_word) begin
      msg_bits += 64'd32;
      load_block_word(req.msg_word);
      return;
    end
    nbytes = (req.byte_count > 3'd4) ? 4 : int'(req.byte_count);
    msg_bits += 64'(nbytes * 8);
    if (nbytes == 4) begin
      load_block_word(req.msg_word);
      load_block_word({PAD_MARK, 24'h0});
    end else begin
      // bytes past the count are dropped and the pad byte follows directly
      keep = (nbytes == 0) ? 32'h0 : ~(32'hffffffff >> (8 * nbytes));
      load_block_word((req.msg_word & keep) | ({24'h0, PAD_MARK} << (24 - 8 * nbytes)));
    end
    // no room left for the length: finish this block with zeros
    if (word_pos > LEN_SLOT) begin
      while (word_pos != 4'd0) load_block_word(32'h0);
    end
    while (word_pos < LEN_SLOT) load_block_word(32'h0);
    load_block_word(msg_bits[63:32]);
    load_block_word(msg_bits[31:0]);
    for (int k = 0; k < 4; k++) begin
      part.digest_part = {hash_st[2 * k], hash_st[2 * k + 1]};
      part.part_index  = 2'(k);
      part.last_part   = (k == 3);
      digest_q.insert(digest_q.size(), part);
    end
    for (int i = 0; i < 8; i++) hash_st[i] = INIT_H[i];
    msg_bits = '0;
    word_pos = '0;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0d ns: digest mismatch: %s", $time, what);
    mismatches++;
  endtask

  // compare output requests first, then predict from the input request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) hash_st[i] = INIT_H[i];
      for (int i = 0; i < 16; i++) blk_words[i] = '0;
      msg_bits = '0;
      word_pos = '0;
      digest_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        parts_seen++;
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("unexpected part %h", out_data_i));
        end else begin
          automatic sh_out_t want = digest_q.pop_front();
          if (out_data_i.digest_part != want.digest_part)
            report_mismatch($sformatf("digest_part got %h want %h",
                                      out_data_i.digest_part, want.digest_part));
          if (out_data_i.part_index != want.part_index)
            report_mismatch($sformatf("part_index got %0d want %0d",
                                      out_data_i.part_index, want.part_index));
          if (out_data_i.last_part != want.last_part)
            report_mismatch($sformatf("last_part got %0d want %0d",
                                      out_data_i.last_part, want.last_part));
        end
      end
      if (in_valid_i && in_ready_i) absorb_word(in_data_i);
    end
    mismatch_count_o <= mismatches;
    pending_o        <= digest_q.size();
    parts_checked_o  <= parts_seen;
  end

endmodule

>>> tb/sv/sha256_hash_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_hash_top_tb
// Feeds directed and random messages into the hasher with bursty input and
// a receiver that stalls in changing patterns; the checker beside the block
// predicts every digest part and counts mismatches for the verdict here.
// ----------------------------------------------------------------------------
module sha256_hash_top_tb;
  import sha256_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 400;
  localparam int DRAIN_CYCLES = 200;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE
  } rx_mode_e;

  logic    clk_i;
  logic    rst_ni;
  logic    in_valid_i;
  logic    in_ready_o;
  sh_in_t  in_data_i;
  logic    out_valid_o;
  logic    out_ready_i;
  sh_out_t out_data_o;

  int mismatch_count;
  int pending_parts;
  int parts_checked;

  int          cycles = 0;
  int          words_sent = 0;
  int          msgs_sent = 0;
  int          directed_msgs = 0;
  int          burst_left = 0;
  int          rx_mode_left = 0;
  int          rx_hold = 0;
  rx_mode_e    rx_mode;
  int unsigned msg_len;
  logic [2:0]  final_count;

  sha256_hash_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  sha256_hash_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .in_data_i       (in_data_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_data_i      (out_data_o),
    .mismatch_count_o(mismatch_count),
    .pending_o       (pending_parts),
    .parts_checked_o (parts_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // run-length guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d parts still pending", cycles, pending_parts);
      $display("sha256_hash_top_tb failed");
      $finish;
    end
  end

  // receiver: open, coin-flip and long-stall phases of random length
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 2));
        rx_mode_left = $urandom_range(50, 300);
      end
      rx_mode_left--;
      case (rx_mode)
        RX_OPEN: begin
          out_ready_i = 1'b1;
        end
        RX_COIN: begin
          out_ready_i = 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_hold > 0) begin
            rx_hold--;
            out_ready_i = 1'b0;
          end else begin
            out_ready_i = 1'b1;
            rx_hold     = $urandom_range(0, 20);
          end
        end
      endcase
    end
  end

  // drive one request, called and returning at a falling edge
  task automatic send_word(input logic [31:0] w, input logic [2:0] cnt, input logic lst);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_data_i.msg_word   = w;
    in_data_i.byte_count = cnt;
    in_data_i.last_word  = lst;
    in_valid_i           = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    words_sent++;
    if (lst) msgs_sent++;
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // empty message, with junk in the ignored bytes
    send_word(32'hdeadbeef, 3'd0, 1'b1);
    // three-byte message
    send_word(32'h61626300, 3'd3, 1'b1);
    // full final word, extremes of the data
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h00000000, 3'd4, 1'b1);
    // unused low bytes must be masked off
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    // counts above four act as four
    send_word(32'h00000000, 3'd5, 1'b1);
    send_word(32'ha5a5a5a5, 3'd6, 1'b1);
    send_word(32'hffffffff, 3'd7, 1'b1);
    // short counts on non-final words are ignored
    send_word(32'h00000000, 3'd0, 1'b0);
    send_word(32'hffffffff, 3'd1, 1'b0);
    send_word(32'h01234567, 3'd2, 1'b1);
    directed_msgs = msgs_sent;

    // random messages, lengths clustered around block boundaries
    while (words_sent < RANDOM_WORDS + 12) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: msg_len = $urandom_range(0, 3);
        5, 6, 7:       msg_len = $urandom_range(12, 17);
        default:       msg_len = $urandom_range(18, 40);
      endcase
      for (int unsigned i = 0; i < msg_len; i++)
        send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
      final_count = ($urandom_range(0, 1) == 0) ? 3'd4 : 3'($urandom_range(0, 7));
      send_word($urandom, final_count, 1'b1);
    end
    in_valid_i = 1'b0;

    while (pending_parts != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("%0d words in %0d messages (%0d directed), %0d digest parts compared",
             words_sent, msgs_sent, directed_msgs, parts_checked);
    $display("bursty input, receiver in open, random and long-stall phases, %0d cycles",
             cycles);
    if (mismatch_count == 0) begin
      $display("sha256_hash_top_tb passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("sha256_hash_top_tb failed");
    end
    $finish;
  end

endmodule
